// File: rtl/bpdc_pkg.sv
// shared types and constants for the button press duration classifier
`default_nettype none
package bpdc_pkg;

	localparam int unsigned CfgIdxW = 8;

	localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE = 8'd0;
	localparam logic [CfgIdxW-1:0] CFG_SHORT    = 8'd1;
	localparam logic [CfgIdxW-1:0] CFG_MEDIUM   = 8'd2;
	localparam logic [CfgIdxW-1:0] CFG_LONG     = 8'd3;

	localparam logic [7:0]  DEBOUNCE_RST = 8'd5;
	localparam logic [15:0] SHORT_RST    = 16'd3000;
	localparam logic [15:0] MEDIUM_RST   = 16'd5000;
	localparam logic [15:0] LONG_RST     = 16'd10000;

	localparam logic [7:0]  STABLE_MAX = 8'hFF;
	localparam logic [15:0] PRESS_MAX  = 16'hFFFF;

	localparam logic [1:0] BLINK_NONE = 2'd0;
	localparam logic [1:0] BLINK_SLOW = 2'd1;
	localparam logic [1:0] BLINK_FAST = 2'd2;

	localparam logic [1:0] CLASS_NONE   = 2'd0;
	localparam logic [1:0] CLASS_SHORT  = 2'd1;
	localparam logic [1:0] CLASS_MEDIUM = 2'd2;
	localparam logic [1:0] CLASS_LONG   = 2'd3;

	typedef struct packed {
		logic [7:0]  debounce_ticks;
		logic [15:0] short_press_ticks;
		logic [15:0] medium_press_ticks;
		logic [15:0] long_press_ticks;
	} cfg_t;

	typedef struct packed {
		logic       debounced_level;
		logic [1:0] press_class;
		logic [1:0] blink_mode;
		logic       blink_restart;
		logic       calibrate_request;
		logic       link_reset_request;
	} result_t;

endpackage
`default_nettype wire

// File: rtl/bpdc_cfg_regs.sv
// configuration register file for the press classifier
`default_nettype none
module bpdc_cfg_regs import bpdc_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [CfgIdxW-1:0] cfg_index,
	input  wire logic [15:0]        cfg_data,
	output cfg_t                    cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks     <= DEBOUNCE_RST;
			cfg_q.short_press_ticks  <= SHORT_RST;
			cfg_q.medium_press_ticks <= MEDIUM_RST;
			cfg_q.long_press_ticks   <= LONG_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_DEBOUNCE: cfg_q.debounce_ticks     <= cfg_data[7:0];
				CFG_SHORT:    cfg_q.short_press_ticks  <= cfg_data;
				CFG_MEDIUM:   cfg_q.medium_press_ticks <= cfg_data;
				CFG_LONG:     cfg_q.long_press_ticks   <= cfg_data;
				default:      ;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: rtl/bpdc_core.sv
// debounce and press classification state with its per-tick update
`default_nettype none
module bpdc_core import bpdc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic step,
	input  wire logic raw,
	input  wire cfg_t cfg,
	output result_t   res,
	output logic [1:0] blink_state
);

	logic        prev_raw_q;
	logic [7:0]  stable_q;
	logic        level_q;
	logic [15:0] press_q;
	logic        short_q, medium_q, long_q;
	logic [1:0]  blink_q;

	logic        prev_raw_d;
	logic [7:0]  stable_d;
	logic        level_d;
	logic [15:0] press_d;
	logic        short_d, medium_d, long_d;
	logic [1:0]  blink_d;
	logic        restart, calib, linkrst;
	logic        timing;

	assign timing = (press_q != '0);

	always_comb begin
		prev_raw_d = raw;
		stable_d   = stable_q;
		level_d    = level_q;
		press_d    = press_q;
		short_d    = short_q;
		medium_d   = medium_q;
		long_d     = long_q;
		blink_d    = blink_q;
		restart    = 1'b0;
		calib      = 1'b0;
		linkrst    = 1'b0;

		if (raw != prev_raw_q)
			stable_d = '0;
		else if (stable_q != STABLE_MAX)
			stable_d = stable_q + 8'd1;

		if ((stable_d > cfg.debounce_ticks) || timing) begin
			if ((raw != level_q) || timing) begin
				level_d = raw;
				if (raw && (press_q < cfg.short_press_ticks))
					press_d = '0;
				if (!raw || (press_d != '0)) begin
					if (press_d != PRESS_MAX)
						press_d = press_d + 16'd1;

					// short window
					if ((press_d >= cfg.short_press_ticks &&
					     press_d <= cfg.medium_press_ticks) || short_d) begin
						if (!short_d)
							restart = 1'b1;
						short_d  = 1'b1;
						medium_d = 1'b0;
						long_d   = 1'b0;
						blink_d  = BLINK_SLOW;
						if (raw) begin
							press_d = '0;
							short_d = 1'b0;
							calib   = 1'b1;
						end
					end
					// medium window
					if ((press_d >= cfg.medium_press_ticks &&
					     press_d <= cfg.long_press_ticks) || medium_d) begin
						if (!medium_d)
							restart = 1'b1;
						short_d  = 1'b0;
						medium_d = 1'b1;
						long_d   = 1'b0;
						blink_d  = BLINK_SLOW;
						if (raw) begin
							press_d  = '0;
							medium_d = 1'b0;
						end
					end
					// long window
					if ((press_d >= cfg.long_press_ticks) || long_d) begin
						if (!long_d)
							restart = 1'b1;
						short_d  = 1'b0;
						medium_d = 1'b0;
						long_d   = 1'b1;
						blink_d  = BLINK_FAST;
						if (raw) begin
							press_d = '0;
							long_d  = 1'b0;
							linkrst = 1'b1;
						end
					end
				end
			end
		end else begin
			level_d = 1'b1;
		end
	end

	always_comb begin
		res.debounced_level    = level_d;
		res.press_class        = long_d ? CLASS_LONG : medium_d ? CLASS_MEDIUM :
		                         short_d ? CLASS_SHORT : CLASS_NONE;
		res.blink_mode         = blink_d;
		res.blink_restart      = restart;
		res.calibrate_request  = calib;
		res.link_reset_request = linkrst;
	end

	assign blink_state = blink_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_raw_q <= 1'b1;
			stable_q   <= '0;
			level_q    <= 1'b0;
			press_q    <= '0;
			short_q    <= 1'b0;
			medium_q   <= 1'b0;
			long_q     <= 1'b0;
			blink_q    <= BLINK_NONE;
		end else if (step) begin
			prev_raw_q <= prev_raw_d;
			stable_q   <= stable_d;
			level_q    <= level_d;
			press_q    <= press_d;
			short_q    <= short_d;
			medium_q   <= medium_d;
			long_q     <= long_d;
			blink_q    <= blink_d;
		end
	end

endmodule
`default_nettype wire

// File: rtl/button_press_duration_classifier_core.sv
// top level of the debounced button press duration classifier
//
// each input beat is one millisecond tick carrying the raw active-low pin
// level; each tick yields exactly one result beat with the debounced level,
// the latched press category, the blink mode and three one-tick pulses
// (blink restart, calibrate request, link reset request)
// input beat: in_valid high and in_stall low; result beat: out_valid high
// and out_stall low
// the input beat is captured in the input register, its state update is
// combinational and the result is captured in the result register, which
// drives out_valid; throughput: one tick per cycle while out_stall is low,
// set by the combinational state update between the two registers
// a stalled result holds in the result register; one more tick waits in
// the input register, after which in_stall rises
// configuration: cfg_valid/cfg_ready write with cfg_index 0..3 for
// debounce, short, medium and long thresholds; other indexes are ignored;
// cfg_ready is always high, write only while the block is idle
// reset: all state and thresholds return to their defaults, both
// registers empty, no clearing pass
`default_nettype none
module button_press_duration_classifier_core import bpdc_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               button_level,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    debounced_level,
	output logic [1:0]              press_class,
	output logic [1:0]              blink_mode,
	output logic                    blink_restart,
	output logic                    calibrate_request,
	output logic                    link_reset_request,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [CfgIdxW-1:0] cfg_index,
	input  wire logic [15:0]        cfg_data
);

	cfg_t       cfg;
	result_t    res;
	result_t    res_s2;
	logic       valid_s1, level_s1;
	logic       valid_s2;
	logic       advance;
	logic [1:0] blink_state;

	bpdc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign advance  = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!in_stall)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			level_s1 <= button_level;
	end

	bpdc_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (valid_s1 && advance),
		.raw         (level_s1),
		.cfg         (cfg),
		.res         (res),
		.blink_state (blink_state)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (advance)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1)
			res_s2 <= res;
	end

	assign out_valid          = valid_s2;
	assign debounced_level    = res_s2.debounced_level;
	assign press_class        = res_s2.press_class;
	assign blink_mode         = res_s2.blink_mode;
	assign blink_restart      = res_s2.blink_restart;
	assign calibrate_request  = res_s2.calibrate_request;
	assign link_reset_request = res_s2.link_reset_request;

	// a latched category always comes with a blink selection
	a_class_blink: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && press_class != CLASS_NONE) |-> (blink_mode != BLINK_NONE))
		else $error("press class latched without blink mode");

	// blink selection never returns to none
	a_blink_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(blink_state != BLINK_NONE) |=> (blink_state != BLINK_NONE))
		else $error("blink selection fell back to none");

	// input side only stalls with a tick waiting behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("input stalled without a full pipeline");

endmodule
`default_nettype wire
